// ===== rtl/assert_macros.svh =====
// Assertion macros used by the page-walk sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FPW_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page walk assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define FPW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page walk assertion failed");

// Condition that must never be seen outside reset.
`define FPW_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("page walk assertion failed");

`endif

// ===== rtl/fpw_pkg.sv =====
// Shared types and constants of the four-level page walk.
package fpw_pkg;

	localparam int TABLE_WORDS_DEF = 4096;

	localparam int PA_W   = 52;
	localparam int VA_W   = 48;
	localparam int WORD_W = 64;
	localparam int WIDX_W = 12;
	localparam int FLAG_W = 12;

	// Request kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	// Page sizes reported in results
	localparam logic [1:0] PAGE_4K = 2'd0;
	localparam logic [1:0] PAGE_2M = 2'd1;
	localparam logic [1:0] PAGE_1G = 2'd2;

	// Level of the entry whose read is outstanding
	localparam logic [1:0] LVL_PML4 = 2'd3;
	localparam logic [1:0] LVL_PDPT = 2'd2;
	localparam logic [1:0] LVL_PD   = 2'd1;
	localparam logic [1:0] LVL_PT   = 2'd0;

	// Entry bit positions
	localparam int BIT_PRESENT = 0;
	localparam int BIT_HUGE    = 7;
	localparam int BIT_NX      = 63;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

// ===== rtl/four_level_page_walk.sv =====
// Top level of the four-level page-table walker over a local table memory.
//
// Usage:
//   Raise start with the request fields while busy is low; the request is
//   taken at that clock edge. action = write stores word_data at word_index
//   (folded to the memory size) in that same edge and produces no result;
//   busy stays low, so write requests stream one per cycle.
//   action = translate walks PML4, PDPT, PD and PT entries from the root
//   table. Each level is one registered read of the table RAM, and the shared
//   address adder forms the next word address from the entry just read.
//   Busy is high from the accepting edge to the edge that raises done, one
//   registered read per level (a miss or a huge page ends the walk early);
//   a full walk is the accepting cycle and four dependent RAM reads. A new
//   request may be taken while done is high.
//   Results: done is high for exactly one cycle with mapped, paddr,
//   flag_bits, no_execute and pg_size; the receiver must take them then.
//   root_table_base is written when root_table_base_we is high; write it
//   only while idle. Reset clears the sequencer and the root base; the
//   table memory is not cleared and must be loaded before any walk reads it.
//   TABLE_WORDS must be a power of two.
module four_level_page_walk #(
	parameter int TABLE_WORDS = fpw_pkg::TABLE_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [fpw_pkg::WIDX_W-1:0]  word_index,
	input  logic [fpw_pkg::WORD_W-1:0]  word_data,
	input  logic [fpw_pkg::VA_W-1:0]    vaddr,
	input  logic                        root_table_base_we,
	input  logic [fpw_pkg::PA_W-1:0]    root_table_base,
	output logic                        done,
	output logic                        mapped,
	output logic [fpw_pkg::PA_W-1:0]    paddr,
	output logic [fpw_pkg::FLAG_W-1:0]  flag_bits,
	output logic                        no_execute,
	output logic [1:0]                  pg_size
);

	localparam int ADDR_W = $clog2(TABLE_WORDS);

	logic [fpw_pkg::PA_W-1:0]   root_q;
	fpw_pkg::mem_ctl_t          mem_ctl;
	logic [fpw_pkg::PA_W-1:0]   op_base;
	logic [fpw_pkg::WIDX_W-1:0] op_idx;
	logic [ADDR_W-1:0]          mem_addr;
	logic [fpw_pkg::WORD_W-1:0] rd_data;

	// Root table base register; low 12 bits are dropped where it is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (root_table_base_we) begin
			root_q <= root_table_base;
		end
	end

	// Sequencer: one level per cycle, result registered on the last level
	fpw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.word_index (word_index),
		.vaddr      (vaddr),
		.root_base  (root_q),
		.rd_data    (rd_data),
		.busy       (busy),
		.mem_ctl    (mem_ctl),
		.op_base    (op_base),
		.op_idx     (op_idx),
		.done       (done),
		.mapped     (mapped),
		.paddr      (paddr),
		.flag_bits  (flag_bits),
		.no_execute (no_execute),
		.pg_size    (pg_size)
	);

	// Shared adder: serves write requests and every walk level
	fpw_addr_unit #(
		.ADDR_W (ADDR_W)
	) u_addr (
		.tbl_base (op_base),
		.idx      (op_idx),
		.addr     (mem_addr)
	);

	// Table memory: written by write requests, read once per walk level
	fpw_ram #(
		.WIDTH (fpw_pkg::WORD_W),
		.DEPTH (TABLE_WORDS)
	) u_table (
		.clk   (clk),
		.we    (mem_ctl.we),
		.re    (mem_ctl.re),
		.addr  (mem_addr),
		.wdata (word_data),
		.rdata (rd_data)
	);

endmodule

// ===== rtl/fpw_ram.sv =====
// Generic single-address RAM with registered read data.
module fpw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/fpw_addr_unit.sv =====
// Shared table-word address unit: (table base / 8 + index) folded to the memory size.
module fpw_addr_unit #(
	parameter int ADDR_W = 12
) (
	input  logic [fpw_pkg::PA_W-1:0]   tbl_base,
	input  logic [fpw_pkg::WIDX_W-1:0] idx,
	output logic [ADDR_W-1:0]          addr
);

	localparam int SUM_W = fpw_pkg::PA_W - 2;

	logic [SUM_W-1:0] sum;

	assign sum  = {1'b0, tbl_base[fpw_pkg::PA_W-1:3]}
		+ {{(SUM_W - fpw_pkg::WIDX_W){1'b0}}, idx};
	// Power-of-two depth: the fold is a plain truncation
	assign addr = sum[ADDR_W-1:0];

endmodule

// ===== rtl/fpw_seq.sv =====
// Walk sequencer: steers the address unit and the table RAM, forms the result.
`include "assert_macros.svh"

module fpw_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         action,
	input  logic [fpw_pkg::WIDX_W-1:0]   word_index,
	input  logic [fpw_pkg::VA_W-1:0]     vaddr,
	input  logic [fpw_pkg::PA_W-1:0]     root_base,
	input  logic [fpw_pkg::WORD_W-1:0]   rd_data,
	output logic                         busy,
	output fpw_pkg::mem_ctl_t            mem_ctl,
	output logic [fpw_pkg::PA_W-1:0]     op_base,
	output logic [fpw_pkg::WIDX_W-1:0]   op_idx,
	output logic                         done,
	output logic                         mapped,
	output logic [fpw_pkg::PA_W-1:0]     paddr,
	output logic [fpw_pkg::FLAG_W-1:0]   flag_bits,
	output logic                         no_execute,
	output logic [1:0]                   pg_size
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t                       state_q;
	logic [1:0]                   level_q;
	logic [fpw_pkg::VA_W-1:0]     va_q;
	logic                         done_q;
	logic                         mapped_q;
	logic [fpw_pkg::PA_W-1:0]     pa_q;
	logic [fpw_pkg::FLAG_W-1:0]   flags_q;
	logic                         nx_q;
	logic [1:0]                   size_q;

	logic                         accept;
	logic                         present;
	logic                         huge;
	logic                         leaf;
	logic [fpw_pkg::PA_W-1:0]     frame;
	logic [8:0]                   next_idx;
	logic [fpw_pkg::PA_W-1:0]     leaf_pa;
	logic [1:0]                   leaf_size;

	assign busy    = (state_q == ST_WALK);
	assign accept  = start && !busy;
	assign present = rd_data[fpw_pkg::BIT_PRESENT];
	assign huge    = rd_data[fpw_pkg::BIT_HUGE];
	assign frame   = {rd_data[fpw_pkg::PA_W-1:12], 12'b0};

	// Stop on a missing entry, a huge PDPT or PD entry, or the PT entry
	assign leaf = !present || (level_q == fpw_pkg::LVL_PT)
		|| (huge && (level_q == fpw_pkg::LVL_PDPT || level_q == fpw_pkg::LVL_PD));

	always_comb begin
		case (level_q)
			fpw_pkg::LVL_PML4: next_idx = va_q[38:30];
			fpw_pkg::LVL_PDPT: next_idx = va_q[29:21];
			fpw_pkg::LVL_PD:   next_idx = va_q[20:12];
			default:           next_idx = 9'd0;
		endcase
	end

	always_comb begin
		case (level_q)
			fpw_pkg::LVL_PDPT: begin
				leaf_pa   = {rd_data[fpw_pkg::PA_W-1:30], va_q[29:0]};
				leaf_size = fpw_pkg::PAGE_1G;
			end
			fpw_pkg::LVL_PD: begin
				leaf_pa   = {rd_data[fpw_pkg::PA_W-1:21], va_q[20:0]};
				leaf_size = fpw_pkg::PAGE_2M;
			end
			default: begin
				leaf_pa   = {rd_data[fpw_pkg::PA_W-1:12], va_q[11:0]};
				leaf_size = fpw_pkg::PAGE_4K;
			end
		endcase
	end

	// Operand steering for the shared address unit
	always_comb begin
		mem_ctl.we = 1'b0;
		mem_ctl.re = 1'b0;
		op_base    = '0;
		op_idx     = '0;
		if (busy) begin
			op_base    = frame;
			op_idx     = {3'b0, next_idx};
			mem_ctl.re = !leaf;
		end else if (action == fpw_pkg::ACT_WRITE) begin
			op_idx     = word_index;
			mem_ctl.we = start;
		end else begin
			op_base    = {root_base[fpw_pkg::PA_W-1:12], 12'b0};
			op_idx     = {3'b0, vaddr[47:39]};
			mem_ctl.re = start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= fpw_pkg::LVL_PML4;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && action == fpw_pkg::ACT_XLATE) begin
						state_q <= ST_WALK;
						level_q <= fpw_pkg::LVL_PML4;
					end
				end
				ST_WALK: begin
					if (leaf) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						level_q <= level_q - 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= vaddr;
		end
		if (busy && leaf) begin
			mapped_q <= present;
			pa_q     <= present ? leaf_pa : '0;
			flags_q  <= present ? rd_data[fpw_pkg::FLAG_W-1:0] : '0;
			nx_q     <= present && rd_data[fpw_pkg::BIT_NX];
			size_q   <= present ? leaf_size : fpw_pkg::PAGE_4K;
		end
	end

	assign done       = done_q;
	assign mapped     = mapped_q;
	assign paddr      = pa_q;
	assign flag_bits  = flags_q;
	assign no_execute = nx_q;
	assign pg_size    = size_q;

	`FPW_ASSERT_NEVER(a_no_rw_clash, mem_ctl.we && mem_ctl.re)
	`FPW_ASSERT_NEXT(a_done_one_cycle, done_q, !done_q)
	`FPW_ASSERT_NEXT(a_xlate_walks, accept && action == fpw_pkg::ACT_XLATE, state_q == ST_WALK)
	`FPW_ASSERT_IMPL(a_unmapped_zero, done_q && !mapped_q,
		pa_q == '0 && size_q == fpw_pkg::PAGE_4K && !nx_q)

endmodule

// ===== tb/tb_four_level_page_walk.sv =====
// Self-checking testbench for the four-level page walker: table loads, walks and root changes.
module tb_four_level_page_walk;
	import fpw_pkg::*;

	localparam int TBL_WORDS      = TABLE_WORDS_DEF;
	localparam int WALK_LATENCY   = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [63:0] ENTRY_FRAME = 64'h000F_FFFF_FFFF_F000;
	localparam logic [51:0] FRAME_4K    = 52'hF_FFFF_FFFF_F000;
	localparam logic [51:0] FRAME_2M    = 52'hF_FFFF_FFE0_0000;
	localparam logic [51:0] FRAME_1G    = 52'hF_FFFF_C000_0000;
	localparam logic [51:0] ROOT_ONES   = 52'hF_FFFF_FFFF_FFFF;

	// One translation outcome, laid out like the result ports
	typedef struct packed {
		logic        mapped;
		logic [51:0] phys;
		logic [11:0] flags;
		logic        nx;
		logic [1:0]  size;
	} xlate_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              action;
	logic [WIDX_W-1:0] word_index;
	logic [WORD_W-1:0] word_data;
	logic [VA_W-1:0]   vaddr;
	logic              root_table_base_we;
	logic [PA_W-1:0]   root_table_base;
	logic              done;
	logic              mapped;
	logic [PA_W-1:0]   paddr;
	logic [FLAG_W-1:0] flag_bits;
	logic              no_execute;
	logic [1:0]        pg_size;

	// Shadow of the table memory and root register, updated as requests are taken
	logic [63:0]       table_copy [TBL_WORDS];
	bit                word_loaded [TBL_WORDS];
	logic [51:0]       root_copy;

	xlate_t            expected_xlates [$];
	logic [47:0]       recent_vas [$];
	int                failures;
	int                items_sent;
	int                sender_gap_pct;
	int                quiet_cycles;

	four_level_page_walk #(
		.TABLE_WORDS(TBL_WORDS)
	) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.action             (action),
		.word_index         (word_index),
		.word_data          (word_data),
		.vaddr              (vaddr),
		.root_table_base_we (root_table_base_we),
		.root_table_base    (root_table_base),
		.done               (done),
		.mapped             (mapped),
		.paddr              (paddr),
		.flag_bits          (flag_bits),
		.no_execute         (no_execute),
		.pg_size            (pg_size)
	);

	always #2 clk = ~clk;

	// Word address of entry idx in the table at tbl_addr, folded to the memory size
	function automatic int unsigned entry_word(input logic [63:0] tbl_addr,
						   input logic [8:0] idx);
		logic [63:0] sum;
		sum = (tbl_addr >> 3) + 64'(idx);
		return int'(sum % TBL_WORDS);
	endfunction

	// Walk the shadow tables for va. Returns 0 if the walk would touch a word
	// never loaded; such a translate must not be issued.
	function automatic bit walk_shadow_tables(input logic [47:0] va, output xlate_t res);
		logic [63:0] tbl;
		logic [63:0] ent;
		int unsigned w;
		res = '0;
		tbl = 64'(root_copy) & ENTRY_FRAME;
		for (int lvl = LVL_PML4; lvl >= 0; lvl--) begin
			w = entry_word(tbl, va[12 + 9 * lvl +: 9]);
			if (!word_loaded[w])
				return 1'b0;
			ent = table_copy[w];
			if (!ent[BIT_PRESENT])
				return 1'b1;
			if ((lvl == LVL_PDPT && ent[BIT_HUGE]) || (lvl == LVL_PD && ent[BIT_HUGE])
					|| lvl == LVL_PT) begin
				res.mapped = 1'b1;
				res.flags  = ent[11:0];
				res.nx     = ent[BIT_NX];
				if (lvl == LVL_PDPT) begin
					res.phys = (ent[51:0] & FRAME_1G) | 52'(va[29:0]);
					res.size = PAGE_1G;
				end else if (lvl == LVL_PD) begin
					res.phys = (ent[51:0] & FRAME_2M) | 52'(va[20:0]);
					res.size = PAGE_2M;
				end else begin
					res.phys = (ent[51:0] & FRAME_4K) | 52'(va[11:0]);
					res.size = PAGE_4K;
				end
				return 1'b1;
			end
			tbl = ent & ENTRY_FRAME;
		end
		return 1'b1;
	endfunction

	// Present one request and hold it until taken; record its effect on the shadow
	task automatic send_request(input logic act, input logic [11:0] idx,
				    input logic [63:0] data, input logic [47:0] va);
		xlate_t res;
		@(negedge clk);
		while ($urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		word_index <= idx;
		word_data  <= data;
		vaddr      <= va;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_WRITE) begin
			table_copy[idx % TBL_WORDS]  = data;
			word_loaded[idx % TBL_WORDS] = 1'b1;
		end else begin
			void'(walk_shadow_tables(va, res));
			expected_xlates.push_back(res);
		end
		items_sent++;
	endtask

	// Translate va only if every word its walk reads has been loaded
	task automatic translate_if_loaded(input logic [47:0] va);
		xlate_t res;
		if (walk_shadow_tables(va, res))
			send_request(ACT_XLATE, '0, '0, va);
	endtask

	// Drop start and hold off until every walk has reported, then let the
	// walker settle
	task automatic wait_walks_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_xlates.size() != 0)
			@(negedge clk);
		repeat (WALK_LATENCY + 1)
			@(negedge clk);
	endtask

	task automatic load_root_table_base(input logic [51:0] value);
		wait_walks_drained();
		root_table_base_we <= 1'b1;
		root_table_base    <= value;
		@(posedge clk);
		root_copy = value;
		@(negedge clk);
		root_table_base_we <= 1'b0;
	endtask

	// Load one random path from the root down for a random address, then translate
	// it and up to two neighbors. Entries are random apart from the present and
	// huge bits, so frames fold onto random tables and high bits and NX vary.
	task automatic build_and_walk();
		logic [47:0] va;
		logic [63:0] tbl;
		logic [63:0] ent;
		int unsigned w;
		int          miss_lvl;
		va       = {16'($urandom), 32'($urandom)};
		miss_lvl = ($urandom_range(4) == 0) ? int'($urandom_range(3)) : -1;
		tbl      = 64'(root_copy) & ENTRY_FRAME;
		for (int lvl = LVL_PML4; lvl >= 0; lvl--) begin
			ent = {$urandom, $urandom};
			ent[BIT_PRESENT] = (lvl != miss_lvl);
			if (lvl == LVL_PDPT || lvl == LVL_PD)
				ent[BIT_HUGE] = ($urandom_range(3) == 0);
			w = entry_word(tbl, va[12 + 9 * lvl +: 9]);
			send_request(ACT_WRITE, 12'(w), ent, va);
			if (!ent[BIT_PRESENT])
				break;
			if ((lvl == LVL_PDPT || lvl == LVL_PD) && ent[BIT_HUGE])
				break;
			tbl = ent & ENTRY_FRAME;
		end
		translate_if_loaded(va);
		repeat ($urandom_range(2)) begin
			va[11:0] = 12'($urandom);
			translate_if_loaded(va);
		end
		recent_vas.push_back(va);
		if (recent_vas.size() > 16)
			void'(recent_vas.pop_front());
	endtask

	// Mostly well-formed paths; the rest is stray table writes, revisits of
	// earlier addresses, wild addresses and full drains
	task automatic run_walk_mix(input int n_items);
		int          stop_at;
		int unsigned pick;
		logic [47:0] va;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				build_and_walk();
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3))
					send_request(ACT_WRITE, 12'($urandom), {$urandom, $urandom},
						     {16'($urandom), 32'($urandom)});
			end else if (pick < 95 && recent_vas.size() != 0) begin
				va = recent_vas[$urandom_range(recent_vas.size() - 1)];
				va[11:0] = 12'($urandom);
				if ($urandom_range(9) < 3)
					va[20:12] = 9'($urandom);
				if ($urandom_range(9) < 2)
					va[29:21] = 9'($urandom);
				translate_if_loaded(va);
			end else if (pick < 97) begin
				wait_walks_drained();
			end else begin
				translate_if_loaded({16'($urandom), 32'($urandom)});
			end
		end
	endtask

	// Hand-built tables in root table 0: a 1G, a 2M and 4K leaves, a miss at
	// each level, an all-ones address, a huge bit at the top level that must
	// be ignored, and a leaf that maps to physical zero
	task automatic test_directed_walks();
		sender_gap_pct = 0;
		load_root_table_base('0);
		send_request(ACT_WRITE, 12'd0,    64'hFFF0_0000_0000_1081, '0);
		send_request(ACT_WRITE, 12'd512,  64'hFFFF_FFFF_FFFF_FFFF, '0);
		send_request(ACT_WRITE, 12'd513,  64'h0000_0000_0000_2001, '0);
		send_request(ACT_WRITE, 12'd514,  64'h7FFF_FFFF_FFFF_FFFE, '0);
		send_request(ACT_WRITE, 12'd1024, 64'h8000_0000_0020_0083, '0);
		send_request(ACT_WRITE, 12'd1025, 64'h0000_0000_0000_3001, '0);
		send_request(ACT_WRITE, 12'd1026, 64'h0000_0000_0000_0000, '0);
		send_request(ACT_WRITE, 12'd1536, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		send_request(ACT_WRITE, 12'd1537, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		send_request(ACT_WRITE, 12'd2047, 64'h0000_0000_0000_0001, '0);
		send_request(ACT_WRITE, 12'd511,  64'h0000_0000_0000_0000, '0);
		send_request(ACT_WRITE, 12'd4095, 64'h5555_AAAA_5555_AAAA, '0);
		send_request(ACT_XLATE, '0, '0, 48'h0000_0000_0000);
		send_request(ACT_XLATE, '0, '0, 48'h0000_401F_FFFF);
		send_request(ACT_XLATE, '0, '0, 48'h0000_4020_0FFF);
		send_request(ACT_XLATE, '0, '0, 48'h0000_4020_1000);
		send_request(ACT_XLATE, '0, '0, 48'h0000_403F_F000);
		send_request(ACT_XLATE, '0, '0, 48'h0000_4040_0000);
		send_request(ACT_XLATE, '0, '0, 48'h0000_8000_0000);
		send_request(ACT_XLATE, '0, '0, 48'hFFFF_FFFF_FFFF);
	endtask

	// Root with every bit set: low bits ignored, table address folds to the top
	task automatic test_walks_sparse_gaps();
		sender_gap_pct = 12;
		load_root_table_base(ROOT_ONES);
		run_walk_mix(240);
	endtask

	task automatic test_walks_dense_gaps();
		sender_gap_pct = 52;
		load_root_table_base({20'($urandom), 32'($urandom)});
		run_walk_mix(240);
	endtask

	// Requests back to back, moving the root between short runs
	task automatic test_walks_back_to_back();
		sender_gap_pct = 0;
		repeat (5) begin
			load_root_table_base({20'($urandom), 32'($urandom)});
			run_walk_mix(50);
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
				   input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			failures++;
		end
	endtask

	// Take every strobed result and match it against the oldest outstanding walk
	always @(posedge clk) begin
		xlate_t want;
		if (arst_n && done) begin
			if (expected_xlates.size() == 0) begin
				$display("%0t: result with no walk outstanding, expected none, actual %h",
					 $time, {mapped, paddr, flag_bits, no_execute, pg_size});
				failures++;
			end else begin
				want = expected_xlates.pop_front();
				check_field("mapped",     64'(want.mapped), 64'(mapped));
				check_field("paddr",      64'(want.phys),   64'(paddr));
				check_field("flag_bits",  64'(want.flags),  64'(flag_bits));
				check_field("no_execute", 64'(want.nx),     64'(no_execute));
				check_field("pg_size",    64'(want.size),   64'(pg_size));
			end
		end
	end

	// Abort if neither a request nor a result moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		start              = 1'b0;
		action             = ACT_WRITE;
		word_index         = '0;
		word_data          = '0;
		vaddr              = '0;
		root_table_base_we = 1'b0;
		root_table_base    = '0;
		root_copy          = '0;
		failures           = 0;
		items_sent         = 0;
		sender_gap_pct     = 0;
		for (int i = 0; i < TBL_WORDS; i++)
			word_loaded[i] = 1'b0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_walks();
		test_walks_sparse_gaps();
		test_walks_dense_gaps();
		test_walks_back_to_back();

		// Hold until the last walk reports, then watch for stray strobes
		wait_walks_drained();
		repeat (2 * WALK_LATENCY)
			@(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
